// ===== sv/tfg_pkg.sv =====
// ============================================================================
// tfg_pkg
// Shared widths, constants and register codes of the triangle face geometry
// unit.
// ============================================================================
package tfg_pkg;

    // Default coordinate width (signed Q14.10)
    localparam int COORD_BITS_DEF = 24;

    // Fixed field widths
    localparam int TAG_W  = 20;
    localparam int NORM_W = 16;
    localparam int AREA_W = 50;

    // Area saturation value and threshold reset value (1.0 in Q.20)
    localparam logic [AREA_W-1:0] AREA_MAX     = {AREA_W{1'b1}};
    localparam logic [AREA_W-1:0] AREA_THR_RST = AREA_W'(1048576);

    // Normal path: quotient n^2 * 2^32 / S never exceeds 2^32, so 33 bits,
    // and its square root fits 17 bits
    localparam int QUO_W   = 33;
    localparam int NROOT_W = 17;

    // +1.0 in Q1.15 and the largest positive code
    localparam logic [NROOT_W-1:0] NORM_ONE     = NROOT_W'(32768);
    localparam logic [NORM_W-1:0]  NORM_POS_MAX = NORM_W'(32767);

    // Register port
    localparam int PDATA_W   = 64;
    localparam int PADDR_W   = 4;
    localparam int REG_SHIFT = 3;
    localparam int REG_IDX_W = PADDR_W - REG_SHIFT;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_AREA_THR = REG_IDX_W'(0);

endpackage

// ===== sv/triangle_face_geometry_unit.sv =====
// ============================================================================
// triangle_face_geometry_unit
// Per-triangle centroid, unit normal and area, fully pipelined.
// ============================================================================
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_face_tag, s_a_x .. s_c_z
//  m_        out        m_valid/m_ready    m_tag_out, m_center_*, m_normal_*,
//                                          m_area, m_keep, m_degenerate
//  apb       in         psel/penable       paddr, pwdata, prdata, pready
//
//  One request enters per cycle while the output is not stalled. The pipeline
//  is 8 + max(50, 2*COORD_BITS+3) register stages (59 at the default width).
//  The depth is set by the restoring square root of the squared normal
//  length, one result bit per stage, and by the 33-stage divider followed
//  by the 17-stage root on the normal path.
//  aresetn (synchronous, active low) clears the valid bits and reloads the
//  threshold with 1.0.
//  A stalled output freezes the whole pipeline; the first stage still takes
//  a request while it is empty.
// ----------------------------------------------------------------------------
module triangle_face_geometry_unit #(
    parameter int COORD_BITS = tfg_pkg::COORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // request channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [tfg_pkg::TAG_W-1:0]              s_face_tag,
    input  logic signed [COORD_BITS-1:0]           s_a_x,
    input  logic signed [COORD_BITS-1:0]           s_a_y,
    input  logic signed [COORD_BITS-1:0]           s_a_z,
    input  logic signed [COORD_BITS-1:0]           s_b_x,
    input  logic signed [COORD_BITS-1:0]           s_b_y,
    input  logic signed [COORD_BITS-1:0]           s_b_z,
    input  logic signed [COORD_BITS-1:0]           s_c_x,
    input  logic signed [COORD_BITS-1:0]           s_c_y,
    input  logic signed [COORD_BITS-1:0]           s_c_z,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [tfg_pkg::TAG_W-1:0]              m_tag_out,
    output logic signed [COORD_BITS-1:0]           m_center_x,
    output logic signed [COORD_BITS-1:0]           m_center_y,
    output logic signed [COORD_BITS-1:0]           m_center_z,
    output logic signed [tfg_pkg::NORM_W-1:0]      m_normal_x,
    output logic signed [tfg_pkg::NORM_W-1:0]      m_normal_y,
    output logic signed [tfg_pkg::NORM_W-1:0]      m_normal_z,
    output logic [tfg_pkg::AREA_W-1:0]             m_area,
    output logic                                   m_keep,
    output logic                                   m_degenerate,
    // register port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tfg_pkg::PADDR_W-1:0]            paddr,
    input  logic [tfg_pkg::PDATA_W-1:0]            pwdata,
    output logic [tfg_pkg::PDATA_W-1:0]            prdata,
    output logic                                   pready
);

    // ------------------------------------------------------------------------
    // Widths
    // ------------------------------------------------------------------------
    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;          // edge vector component
    localparam int PW    = 2 * DW;          // component product
    localparam int CRW   = PW + 1;          // cross product component, signed
    localparam int MW    = PW;              // its magnitude
    localparam int LO_W  = MW / 2;
    localparam int HI_W  = MW - LO_W;
    localparam int N2W   = 2 * MW;          // squared component
    localparam int SW    = N2W + 2;         // squared length
    localparam int RA_W  = SW / 2;          // root of squared length
    localparam int QW    = tfg_pkg::QUO_W;
    localparam int NR_W  = tfg_pkg::NROOT_W;
    localparam int NRM_W = NR_W + 2;        // normal root remainder
    localparam int ARM_W = RA_W + 2;        // area root remainder
    localparam int NW    = tfg_pkg::NORM_W;
    localparam int AW    = tfg_pkg::AREA_W;
    localparam int CMPW  = (RA_W > AW) ? RA_W : AW;

    // Centroid: floor((sum+1)/3) through a reciprocal multiply on an offset sum
    localparam int XW3    = CW + 2;
    localparam int RCP_K  = XW3 + 2;
    localparam int RCP_W  = RCP_K - 1;
    localparam int CPW    = XW3 + RCP_W;
    localparam logic [RCP_W-1:0] RCP_M =
        RCP_W'(((64'd1 << RCP_K) + 64'd2) / 64'd3);
    localparam logic [XW3-1:0] CTR_OFF = XW3'(3) << (CW - 1);

    // ------------------------------------------------------------------------
    // Stage numbers
    // ------------------------------------------------------------------------
    localparam int LANE_LEN = ((QW + NR_W) > RA_W) ? (QW + NR_W) : RA_W;
    localparam int ST_DIFF  = 1;
    localparam int ST_PROD  = 2;
    localparam int ST_CROSS = 3;
    localparam int ST_MAG   = 4;
    localparam int ST_PART  = 5;
    localparam int ST_SQ    = 6;
    localparam int ST_SUM   = 7;
    localparam int ST_LANE0 = 8;
    localparam int ST_OUT   = ST_LANE0 + LANE_LEN;
    localparam int ST_LAST  = ST_OUT - 1;

    // ------------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------------
    logic [ST_OUT:1] vld_reg;
    logic            adv;
    logic            ld1;

    // advance everything when the output slot is free; fill an empty front
    assign adv     = !vld_reg[ST_OUT] || m_ready;
    assign ld1     = adv || !vld_reg[ST_DIFF];
    assign s_ready = ld1;
    assign m_valid = vld_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (ld1) begin
                vld_reg[ST_DIFF] <= s_valid;
            end
            if (adv) begin
                vld_reg[ST_OUT:ST_PROD] <= vld_reg[ST_OUT-1:ST_DIFF];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    logic [AW-1:0]                 thr_reg;
    logic [tfg_pkg::REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[tfg_pkg::PADDR_W-1:tfg_pkg::REG_SHIFT];
    assign pready  = 1'b1;

    // write the threshold; ignore addresses beyond the register list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= tfg_pkg::AREA_THR_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                tfg_pkg::REG_AREA_THR: thr_reg <= pwdata[AW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tfg_pkg::REG_AREA_THR: prdata = tfg_pkg::PDATA_W'(thr_reg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Vertex arrays
    // ------------------------------------------------------------------------
    logic signed [CW-1:0] va [3];
    logic signed [CW-1:0] vb [3];
    logic signed [CW-1:0] vc [3];

    assign va[0] = s_a_x;  assign va[1] = s_a_y;  assign va[2] = s_a_z;
    assign vb[0] = s_b_x;  assign vb[1] = s_b_y;  assign vb[2] = s_b_z;
    assign vc[0] = s_c_x;  assign vc[1] = s_c_y;  assign vc[2] = s_c_z;

    // ------------------------------------------------------------------------
    // Pipeline storage
    // ------------------------------------------------------------------------
    logic [tfg_pkg::TAG_W-1:0] tag_reg  [ST_DIFF:ST_LAST];
    logic signed [DW-1:0]      du_reg   [3];
    logic signed [DW-1:0]      dv_reg   [3];
    logic [XW3-1:0]            cs_reg   [3];
    logic signed [PW-1:0]      pa_reg   [3];
    logic signed [PW-1:0]      pb_reg   [3];
    logic [CPW-1:0]            cp_reg   [3];
    logic signed [CRW-1:0]     cr_reg   [3];
    logic [CW-1:0]             ctr_reg  [ST_CROSS:ST_LAST][3];
    logic [2:0]                neg_reg  [ST_MAG:ST_LAST];
    logic [MW-1:0]             mag_reg  [3];
    logic [2*HI_W-1:0]         hh_reg   [3];
    logic [MW-1:0]             hl_reg   [3];
    logic [2*LO_W-1:0]         ll_reg   [3];
    logic [N2W-1:0]            n2_reg   [ST_SQ:ST_SUM][3];
    logic [SW-1:0]             s_reg    [ST_SUM:ST_OUT-2];
    logic                      degen_reg[ST_LANE0:ST_LAST];
    logic [SW-1:0]             rem_reg  [ST_LANE0:ST_LANE0+QW-1][3];
    logic [QW-1:0]             quo_reg  [ST_LANE0:ST_OUT-2][3];
    logic [NRM_W-1:0]          nrem_reg [ST_LANE0+QW:ST_LAST][3];
    logic [NR_W-1:0]           nroot_reg[ST_LANE0+QW:ST_LAST][3];
    logic [ARM_W-1:0]          arem_reg [ST_LANE0:ST_LAST];
    logic [RA_W-1:0]           aroot_reg[ST_LANE0:ST_LAST];

    // ------------------------------------------------------------------------
    // Tag delay line
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ld1) begin
            tag_reg[ST_DIFF] <= s_face_tag;
        end
    end

    for (genvar k = ST_PROD; k <= ST_LAST; k++) begin : g_tag
        always_ff @(posedge aclk) begin
            if (adv) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Front stages, one lane per axis
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < 3; g++) begin : g_axis
        localparam int G1 = (g + 1) % 3;
        localparam int G2 = (g + 2) % 3;

        logic signed [DW-1:0]  du_next;
        logic signed [DW-1:0]  dv_next;
        logic [XW3-1:0]        cs_next;
        logic [CW-1:0]         cq;
        logic [HI_W-1:0]       mhi;
        logic [LO_W-1:0]       mlo;

        // edge vectors and offset coordinate sum (+1 for rounding)
        assign du_next = DW'(vb[g]) - DW'(va[g]);
        assign dv_next = DW'(vc[g]) - DW'(va[g]);
        assign cs_next = XW3'(va[g]) + XW3'(vb[g]) + XW3'(vc[g])
                       + XW3'(1) + CTR_OFF;

        always_ff @(posedge aclk) begin
            if (ld1) begin
                du_reg[g] <= du_next;
                dv_reg[g] <= dv_next;
                cs_reg[g] <= cs_next;
            end
        end

        // cross product terms and reciprocal multiply
        always_ff @(posedge aclk) begin
            if (adv) begin
                pa_reg[g] <= PW'(du_reg[G1]) * PW'(dv_reg[G2]);
                pb_reg[g] <= PW'(du_reg[G2]) * PW'(dv_reg[G1]);
                cp_reg[g] <= CPW'(cs_reg[g]) * CPW'(RCP_M);
            end
        end

        // quotient of the offset sum, then remove the offset by flipping the MSB
        assign cq = cp_reg[g][RCP_K +: CW];

        always_ff @(posedge aclk) begin
            if (adv) begin
                cr_reg[g]           <= CRW'(pa_reg[g]) - CRW'(pb_reg[g]);
                ctr_reg[ST_CROSS][g] <= {~cq[CW-1], cq[CW-2:0]};
            end
        end

        // sign and magnitude
        always_ff @(posedge aclk) begin
            if (adv) begin
                neg_reg[ST_MAG][g] <= cr_reg[g][CRW-1];
                mag_reg[g]         <= cr_reg[g][CRW-1] ? MW'(-cr_reg[g])
                                                       : MW'(cr_reg[g]);
            end
        end

        // square the magnitude as three partial products
        assign mhi = mag_reg[g][MW-1:LO_W];
        assign mlo = mag_reg[g][LO_W-1:0];

        always_ff @(posedge aclk) begin
            if (adv) begin
                hh_reg[g] <= (2*HI_W)'(mhi) * (2*HI_W)'(mhi);
                hl_reg[g] <= MW'(mhi) * MW'(mlo);
                ll_reg[g] <= (2*LO_W)'(mlo) * (2*LO_W)'(mlo);
            end
        end

        // combine partial products
        always_ff @(posedge aclk) begin
            if (adv) begin
                n2_reg[ST_SQ][g]  <= (N2W'(hh_reg[g]) << (2*LO_W))
                                   + (N2W'(hl_reg[g]) << (LO_W + 1))
                                   + N2W'(ll_reg[g]);
                n2_reg[ST_SUM][g] <= n2_reg[ST_SQ][g];
            end
        end

        // hold centroid through the pipeline
        for (genvar k = ST_CROSS + 1; k <= ST_LAST; k++) begin : g_ctr
            always_ff @(posedge aclk) begin
                if (adv) begin
                    ctr_reg[k][g] <= ctr_reg[k-1][g];
                end
            end
        end

        // --------------------------------------------------------------------
        // Normal lane: divide n^2 * 2^32 by S, one quotient bit a stage
        // --------------------------------------------------------------------
        for (genvar j = 0; j < QW; j++) begin : g_div
            localparam int K = ST_LANE0 + j;
            logic [SW:0]   dt;
            logic [SW:0]   dsub;
            logic          dge;
            logic [QW-1:0] qprev;

            if (j == 0) begin : g_first
                assign dt    = (SW+1)'(n2_reg[ST_SUM][g]);
                assign qprev = '0;
            end else begin : g_next
                assign dt    = {rem_reg[K-1][g], 1'b0};
                assign qprev = quo_reg[K-1][g];
            end

            assign dsub = dt - (SW+1)'(s_reg[K-1]);
            assign dge  = (dt >= (SW+1)'(s_reg[K-1]));

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[K][g] <= dge ? dsub[SW-1:0] : dt[SW-1:0];
                    quo_reg[K][g] <= {qprev[QW-2:0], dge};
                end
            end
        end

        // hold the quotient while its root is taken
        for (genvar k = ST_LANE0 + QW; k <= ST_OUT - 2; k++) begin : g_quo
            always_ff @(posedge aclk) begin
                if (adv) begin
                    quo_reg[k][g] <= quo_reg[k-1][g];
                end
            end
        end

        // square root of the quotient, one root bit a stage, then hold
        for (genvar j = QW; j < LANE_LEN; j++) begin : g_nsq
            localparam int K = ST_LANE0 + j;
            localparam int I = j - QW;

            if (I < NR_W) begin : g_step
                logic [2*NR_W-1:0] rad;
                logic [NRM_W-1:0]  rprev;
                logic [NR_W-1:0]   oprev;
                logic [NRM_W-1:0]  rt;
                logic [NRM_W-1:0]  trial;
                logic              rge;

                assign rad = (2*NR_W)'(quo_reg[K-1][g]);

                if (I == 0) begin : g_first
                    assign rprev = '0;
                    assign oprev = '0;
                end else begin : g_next
                    assign rprev = nrem_reg[K-1][g];
                    assign oprev = nroot_reg[K-1][g];
                end

                assign rt    = {rprev[NRM_W-3:0], rad[2*NR_W-1-2*I -: 2]};
                assign trial = {oprev, 2'b01};
                assign rge   = (rt >= trial);

                always_ff @(posedge aclk) begin
                    if (adv) begin
                        nrem_reg[K][g]  <= rge ? (rt - trial) : rt;
                        nroot_reg[K][g] <= {oprev[NR_W-2:0], rge};
                    end
                end
            end else begin : g_hold
                always_ff @(posedge aclk) begin
                    if (adv) begin
                        nrem_reg[K][g]  <= nrem_reg[K-1][g];
                        nroot_reg[K][g] <= nroot_reg[K-1][g];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sign delay line
    // ------------------------------------------------------------------------
    for (genvar k = ST_MAG + 1; k <= ST_LAST; k++) begin : g_neg
        always_ff @(posedge aclk) begin
            if (adv) begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Squared length, its copies and the degenerate flag
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            s_reg[ST_SUM] <= SW'(n2_reg[ST_SQ][0]) + SW'(n2_reg[ST_SQ][1])
                           + SW'(n2_reg[ST_SQ][2]);
            degen_reg[ST_LANE0] <= (s_reg[ST_SUM] == '0);
        end
    end

    for (genvar k = ST_LANE0; k <= ST_OUT - 2; k++) begin : g_s
        always_ff @(posedge aclk) begin
            if (adv) begin
                s_reg[k] <= s_reg[k-1];
            end
        end
    end

    for (genvar k = ST_LANE0 + 1; k <= ST_LAST; k++) begin : g_degen
        always_ff @(posedge aclk) begin
            if (adv) begin
                degen_reg[k] <= degen_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Area lane: square root of S, one root bit a stage, then hold
    // ------------------------------------------------------------------------
    for (genvar j = 0; j < LANE_LEN; j++) begin : g_asq
        localparam int K = ST_LANE0 + j;

        if (j < RA_W) begin : g_step
            logic [ARM_W-1:0] rprev;
            logic [RA_W-1:0]  oprev;
            logic [ARM_W-1:0] rt;
            logic [ARM_W-1:0] trial;
            logic             rge;

            if (j == 0) begin : g_first
                assign rprev = '0;
                assign oprev = '0;
            end else begin : g_next
                assign rprev = arem_reg[K-1];
                assign oprev = aroot_reg[K-1];
            end

            assign rt    = {rprev[ARM_W-3:0], s_reg[K-1][SW-1-2*j -: 2]};
            assign trial = {oprev, 2'b01};
            assign rge   = (rt >= trial);

            always_ff @(posedge aclk) begin
                if (adv) begin
                    arem_reg[K]  <= rge ? (rt - trial) : rt;
                    aroot_reg[K] <= {oprev[RA_W-2:0], rge};
                end
            end
        end else begin : g_hold
            always_ff @(posedge aclk) begin
                if (adv) begin
                    arem_reg[K]  <= arem_reg[K-1];
                    aroot_reg[K] <= aroot_reg[K-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output stage: round the roots, saturate, apply signs
    // ------------------------------------------------------------------------
    logic [RA_W:0]      area_sum;
    logic [RA_W-1:0]    area_half;
    logic [AW-1:0]      area_next;
    logic               keep_next;
    logic [NW-1:0]      norm_next [3];

    logic [AW-1:0]      area_reg;
    logic               keep_reg;
    logic               degen_out_reg;
    logic [tfg_pkg::TAG_W-1:0] tag_out_reg;
    logic [CW-1:0]      ctr_out_reg  [3];
    logic [NW-1:0]      norm_out_reg [3];

    // largest m with (2m-1) at most the root, clamped to the area range
    assign area_sum  = (RA_W+1)'(aroot_reg[ST_LAST]) + (RA_W+1)'(1);
    assign area_half = area_sum[RA_W:1];

    always_comb begin
        if (CMPW'(area_half) > CMPW'(tfg_pkg::AREA_MAX)) begin
            area_next = tfg_pkg::AREA_MAX;
        end else begin
            area_next = AW'(area_half);
        end
    end

    assign keep_next = (area_next < thr_reg);

    for (genvar g = 0; g < 3; g++) begin : g_norm
        logic [NR_W:0]   nsum;
        logic [NR_W-1:0] nmag;

        assign nsum = (NR_W+1)'(nroot_reg[ST_LAST][g]) + (NR_W+1)'(1);
        assign nmag = degen_reg[ST_LAST] ? '0 : nsum[NR_W:1];

        // negate, or clamp +1.0 to the largest positive code
        always_comb begin
            if (neg_reg[ST_LAST][g]) begin
                norm_next[g] = NW'(NR_W'(0) - nmag);
            end else if (nmag >= tfg_pkg::NORM_ONE) begin
                norm_next[g] = tfg_pkg::NORM_POS_MAX;
            end else begin
                norm_next[g] = NW'(nmag);
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                ctr_out_reg[g]  <= ctr_reg[ST_LAST][g];
                norm_out_reg[g] <= norm_next[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            area_reg      <= area_next;
            keep_reg      <= keep_next;
            degen_out_reg <= degen_reg[ST_LAST];
            tag_out_reg   <= tag_reg[ST_LAST];
        end
    end

    assign m_tag_out    = tag_out_reg;
    assign m_center_x   = ctr_out_reg[0];
    assign m_center_y   = ctr_out_reg[1];
    assign m_center_z   = ctr_out_reg[2];
    assign m_normal_x   = norm_out_reg[0];
    assign m_normal_y   = norm_out_reg[1];
    assign m_normal_z   = norm_out_reg[2];
    assign m_area       = area_reg;
    assign m_keep       = keep_reg;
    assign m_degenerate = degen_out_reg;

endmodule
